// ===== design/etd_pkg.sv =====
package etd_pkg;

    // Pipeline control shared by every stage of the root and divider pipelines: advance enable and item valid.
    typedef struct packed {
        logic en;
        logic valid;
    } etd_ctl_t;

    // Register index of min_norm_threshold (byte address 4 * index).
    localparam logic REG_MIN_NORM = 1'b0;

    localparam int THR_W = 16;

endpackage

// ===== design/edge_tangent_direction.sv =====
// Channel  | Dir | Signals                               | Content
// s_axis   | in  | s_tvalid s_tready s_tdata             | tensor E, F, G, invalid mask
// m_axis   | out | m_tvalid m_tready m_tdata m_tuser     | dir x, dir y, degenerate flag
// apb      | in  | psel penable pwrite paddr pwdata ...  | min_norm_threshold at 0x0
//
// One item per clock sustained while m_tready does not stall the output. The path runs
// through registered stages, two root pipelines and the divider, one bit per stage.
// Reset (rst_n, async low) clears valid bits and the threshold register.
// A stall on m_tready freezes the whole pipeline; s_tready drops with it.
module edge_tangent_direction #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [W-1:0] tensor_e, [2W-1:W] tensor_f, [3W-1:2W] tensor_g, [3W+2:3W] invalid_mask
    input  logic [((3*SAMPLE_WIDTH+3+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [W-1:0] dir_x, [2W-1:W] dir_y
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
    // [0] degenerate
    output logic                 m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int W    = SAMPLE_WIDTH;
    localparam int AW   = W + 1;       // a = E-G, b = 2F
    localparam int S1W  = 2 * W + 3;   // a^2 + b^2
    localparam int DR   = W + 2;       // d
    localparam int VW   = W + 3;       // vy signed
    localparam int UW   = W + 2;       // |vx|, |vy|
    localparam int S2W  = 2 * W + 5;   // vx^2 + vy^2
    localparam int MR   = W + 3;       // m
    localparam int DW   = W + 4;       // divisor 2m
    localparam int ODW  = ((2 * W + 7) / 8) * 8;
    localparam logic [W-1:0] FULL_M1 = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] FULL    = {1'b1, {(W-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [etd_pkg::THR_W-1:0] thr_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == etd_pkg::REG_MIN_NORM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_wr)
            thr_reg <= pwdata[etd_pkg::THR_W-1:0];
    end

    assign prdata = (paddr[2] == etd_pkg::REG_MIN_NORM) ?
                    32'(thr_reg) : 32'd0;

    // ---------------- flow control ----------------
    logic              out_valid_reg;
    logic              en;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage 1: mask, differences ----------------
    logic signed [W-1:0]  e_in, f_in, g_in;
    logic [2:0]           inv;
    logic signed [AW-1:0] a_reg, b_reg;
    logic                 v1_reg;

    always_comb
    begin
        inv  = s_tdata[3*W+2:3*W];
        e_in = inv[0] ? '0 : $signed(s_tdata[W-1:0]);
        f_in = inv[1] ? '0 : $signed(s_tdata[2*W-1:W]);
        g_in = inv[2] ? '0 : $signed(s_tdata[3*W-1:2*W]);
    end

    // ---------------- stage 2: squares ----------------
    logic [AW-1:0]        ua, ub;
    logic [S1W-1:0]       sq1_reg;
    logic signed [AW-1:0] a2_reg, b2_reg;
    logic                 v2_reg;

    assign ua = a_reg[AW-1] ? AW'(-a_reg) : AW'(a_reg);
    assign ub = b_reg[AW-1] ? AW'(-b_reg) : AW'(b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= {e_in[W-1], e_in} - {g_in[W-1], g_in};
            b_reg   <= {f_in, 1'b0};
            sq1_reg <= S1W'(ua * ua) + S1W'(ub * ub);
            a2_reg  <= a_reg;
            b2_reg  <= b_reg;
        end
    end

    // ---------------- d = sqrt(a^2 + b^2) ----------------
    etd_pkg::etd_ctl_t    ctl_sq1;
    logic                 vd;
    logic [DR-1:0]        d_root;
    logic [2*AW-1:0]      ab_side;

    assign ctl_sq1 = '{en: en, valid: v2_reg};

    etd_sqrt_pipe #(.IN_W(S1W), .P_W(2 * AW)) u_sqrt_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_sq1),
        .radicand  (sq1_reg),
        .side_in   ({a2_reg, b2_reg}),
        .valid_out (vd),
        .root      (d_root),
        .side_out  (ab_side)
    );

    // ---------------- stage 3: eigenvector v = (b, -a-d) ----------------
    logic signed [AW-1:0] a_d, b_d;
    logic signed [VW-1:0] vy;
    logic [UW-1:0]        ux_reg, uy_reg;
    logic                 sx_reg, sy_reg, v3_reg;

    assign a_d = $signed(ab_side[2*AW-1:AW]);
    assign b_d = $signed(ab_side[AW-1:0]);
    assign vy  = -VW'(a_d) - $signed({1'b0, d_root});

    // ---------------- stage 4: squares of v ----------------
    logic [S2W-1:0] sq2_reg;
    logic [UW-1:0]  ux4_reg, uy4_reg;
    logic           sx4_reg, sy4_reg, v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= vd;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg  <= b_d[AW-1] ? UW'(-b_d) : UW'(b_d);
            uy_reg  <= vy[VW-1] ? UW'(-vy) : UW'(vy);
            sx_reg  <= b_d[AW-1];
            sy_reg  <= vy[VW-1];
            sq2_reg <= S2W'(ux_reg * ux_reg) + S2W'(uy_reg * uy_reg);
            ux4_reg <= ux_reg;
            uy4_reg <= uy_reg;
            sx4_reg <= sx_reg;
            sy4_reg <= sy_reg;
        end
    end

    // ---------------- m = |v| ----------------
    etd_pkg::etd_ctl_t ctl_sq2;
    logic              vm;
    logic [MR-1:0]     m_root;
    logic [2*UW+1:0]   v_side;

    assign ctl_sq2 = '{en: en, valid: v4_reg};

    etd_sqrt_pipe #(.IN_W(S2W), .P_W(2 * UW + 2)) u_sqrt_m (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_sq2),
        .radicand  (sq2_reg),
        .side_in   ({sx4_reg, sy4_reg, ux4_reg, uy4_reg}),
        .valid_out (vm),
        .root      (m_root),
        .side_out  (v_side)
    );

    // ---------------- stage 5: threshold, divider operands ----------------
    // component = round(|v| * 2^(W-1) / m) = floor((|v|*2^W + m) / (2m))
    logic [DW-1:0] nx_hi_reg, ny_hi_reg, den_reg;
    logic [W-1:0]  n_lo_reg;
    logic          deg_reg, sx5_reg, sy5_reg, v5_reg;
    logic [UW-1:0] ux_m, uy_m;

    assign ux_m = v_side[2*UW-1:UW];
    assign uy_m = v_side[UW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= vm;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_hi_reg <= DW'(ux_m) + DW'(m_root >> W);
            ny_hi_reg <= DW'(uy_m) + DW'(m_root >> W);
            n_lo_reg  <= m_root[W-1:0];
            den_reg   <= {m_root, 1'b0};
            deg_reg   <= (DW'(m_root) <= DW'(thr_reg));
            sx5_reg   <= v_side[2*UW+1];
            sy5_reg   <= v_side[2*UW];
        end
    end

    // ---------------- dividers ----------------
    etd_pkg::etd_ctl_t ctl_div;
    logic              vq, vq_y;
    logic [W-1:0]      qx, qy;
    logic [1:0]        x_side;
    logic              y_side;

    assign ctl_div = '{en: en, valid: v5_reg};

    etd_div_pipe #(.Q_W(W), .D_W(DW), .P_W(2)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_div),
        .num_hi    (nx_hi_reg),
        .num_lo    (n_lo_reg),
        .den       (den_reg),
        .side_in   ({deg_reg, sx5_reg}),
        .valid_out (vq),
        .quot      (qx),
        .side_out  (x_side)
    );

    etd_div_pipe #(.Q_W(W), .D_W(DW), .P_W(1)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_div),
        .num_hi    (ny_hi_reg),
        .num_lo    (n_lo_reg),
        .den       (den_reg),
        .side_in   (sy5_reg),
        .valid_out (vq_y),
        .quot      (qy),
        .side_out  (y_side)
    );

    // ---------------- output: saturate, sign, fallback ----------------
    logic [W-1:0] dx_next, dy_next, qcx, qcy;
    logic [W-1:0] dx_reg, dy_reg;
    logic         deg_out_reg;

    always_comb
    begin
        // negative side may reach full scale, positive stops one short
        if (x_side[0])
        begin
            qcx     = (qx > FULL) ? FULL : qx;
            dx_next = W'(-qcx);
        end
        else
        begin
            qcx     = (qx > FULL_M1) ? FULL_M1 : qx;
            dx_next = qcx;
        end
        if (y_side)
        begin
            qcy     = (qy > FULL) ? FULL : qy;
            dy_next = W'(-qcy);
        end
        else
        begin
            qcy     = (qy > FULL_M1) ? FULL_M1 : qy;
            dy_next = qcy;
        end
        if (x_side[1])
        begin
            dx_next = '0;
            dy_next = FULL_M1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vq && vq_y;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            deg_out_reg <= x_side[1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ODW'({dy_reg, dx_reg});
    assign m_tuser  = deg_out_reg;

`ifndef SYNTH
    // fallback result is always (0, +max)
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (dx_reg == '0 && dy_reg == FULL_M1))
        else $error("degenerate item without fallback direction");

    // a held result stalls the input side
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // both divider lanes stay in step
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        vq == vq_y)
        else $error("divider lanes out of step");

    // threshold write lands
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (thr_reg == $past(pwdata[etd_pkg::THR_W-1:0])))
        else $error("threshold write lost");
`endif

endmodule

// ===== design/etd_sqrt_pipe.sv =====
// Integer square root, one root bit per stage (digit recurrence).
module etd_sqrt_pipe #(
    parameter int IN_W = 35,
    parameter int P_W  = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  etd_pkg::etd_ctl_t      ctl,
    input  logic [IN_W-1:0]        radicand,
    input  logic [P_W-1:0]         side_in,
    output logic                   valid_out,
    output logic [(IN_W+1)/2-1:0]  root,
    output logic [P_W-1:0]         side_out
);

    localparam int R  = (IN_W + 1) / 2;
    localparam int RW = R + 3;

    logic [2*R-1:0] n_in    [0:R-1];
    logic [RW-1:0]  rem_in  [0:R-1];
    logic [R-1:0]   root_in [0:R-1];
    logic [P_W-1:0] side_in_s [0:R-1];
    logic           v_in    [0:R-1];

    logic [2*R-1:0] n_reg    [1:R];
    logic [RW-1:0]  rem_reg  [1:R];
    logic [R-1:0]   root_reg [1:R];
    logic [P_W-1:0] side_reg [1:R];
    logic           v_reg    [1:R];

    genvar i;
    generate
        for (i = 0; i < R; i++)
        begin : g_stage
            logic [RW-1:0] rem_sh;
            logic [RW-1:0] trial;
            logic [RW-1:0] rem_next;
            logic [R-1:0]  root_next;

            if (i == 0)
            begin : g_first
                assign n_in[i]      = (2*R)'(radicand);
                assign rem_in[i]    = '0;
                assign root_in[i]   = '0;
                assign side_in_s[i] = side_in;
                assign v_in[i]      = ctl.valid;
            end
            else
            begin : g_rest
                assign n_in[i]      = n_reg[i];
                assign rem_in[i]    = rem_reg[i];
                assign root_in[i]   = root_reg[i];
                assign side_in_s[i] = side_reg[i];
                assign v_in[i]      = v_reg[i];
            end

            always_comb
            begin
                rem_sh = {rem_in[i][RW-3:0], n_in[i][2*R-1-2*i -: 2]};
                trial  = RW'({root_in[i], 2'b01});
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_in[i][R-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_in[i][R-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i+1] <= 1'b0;
                else if (ctl.en)
                    v_reg[i+1] <= v_in[i];
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    n_reg[i+1]    <= n_in[i];
                    rem_reg[i+1]  <= rem_next;
                    root_reg[i+1] <= root_next;
                    side_reg[i+1] <= side_in_s[i];
                end
            end
        end
    endgenerate

    assign valid_out = v_reg[R];
    assign root      = root_reg[R];
    assign side_out  = side_reg[R];

endmodule

// ===== design/etd_div_pipe.sv =====
// Restoring divider, one quotient bit per stage. Quotient must fit Q_W bits.
module etd_div_pipe #(
    parameter int Q_W = 16,
    parameter int D_W = 20,
    parameter int P_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  etd_pkg::etd_ctl_t ctl,
    input  logic [D_W-1:0]    num_hi,
    input  logic [Q_W-1:0]    num_lo,
    input  logic [D_W-1:0]    den,
    input  logic [P_W-1:0]    side_in,
    output logic              valid_out,
    output logic [Q_W-1:0]    quot,
    output logic [P_W-1:0]    side_out
);

    logic [D_W-1:0] rem_in  [0:Q_W-1];
    logic [Q_W-1:0] lo_in   [0:Q_W-1];
    logic [D_W-1:0] den_in  [0:Q_W-1];
    logic [Q_W-1:0] q_in    [0:Q_W-1];
    logic [P_W-1:0] side_s  [0:Q_W-1];
    logic           v_in    [0:Q_W-1];

    logic [D_W-1:0] rem_reg  [1:Q_W];
    logic [Q_W-1:0] lo_reg   [1:Q_W];
    logic [D_W-1:0] den_reg  [1:Q_W];
    logic [Q_W-1:0] q_reg    [1:Q_W];
    logic [P_W-1:0] side_reg [1:Q_W];
    logic           v_reg    [1:Q_W];

    genvar i;
    generate
        for (i = 0; i < Q_W; i++)
        begin : g_stage
            logic [D_W:0]   r2;
            logic [D_W-1:0] rem_next;
            logic [Q_W-1:0] q_next;

            if (i == 0)
            begin : g_first
                assign rem_in[i] = num_hi;
                assign lo_in[i]  = num_lo;
                assign den_in[i] = den;
                assign q_in[i]   = '0;
                assign side_s[i] = side_in;
                assign v_in[i]   = ctl.valid;
            end
            else
            begin : g_rest
                assign rem_in[i] = rem_reg[i];
                assign lo_in[i]  = lo_reg[i];
                assign den_in[i] = den_reg[i];
                assign q_in[i]   = q_reg[i];
                assign side_s[i] = side_reg[i];
                assign v_in[i]   = v_reg[i];
            end

            always_comb
            begin
                r2 = {rem_in[i], lo_in[i][Q_W-1-i]};
                if (r2 >= {1'b0, den_in[i]})
                begin
                    rem_next = D_W'(r2 - {1'b0, den_in[i]});
                    q_next   = {q_in[i][Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = D_W'(r2);
                    q_next   = {q_in[i][Q_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i+1] <= 1'b0;
                else if (ctl.en)
                    v_reg[i+1] <= v_in[i];
            end

            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    rem_reg[i+1]  <= rem_next;
                    lo_reg[i+1]   <= lo_in[i];
                    den_reg[i+1]  <= den_in[i];
                    q_reg[i+1]    <= q_next;
                    side_reg[i+1] <= side_s[i];
                end
            end
        end
    endgenerate

    assign valid_out = v_reg[Q_W];
    assign quot      = q_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule
